// ----- design/mexp_pkg.sv -----
// shared constants and controller/datapath interface types for modular exponentiation
`default_nettype none
package mexp_pkg;

  localparam int unsigned DEF_WIDTH = 16;
  localparam int unsigned MOD_RESET = 101;

  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_init;
    logic init_sel_b;
    logic mul_step;
    logic mul_commit;
    logic exp_shift;
    logic out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic exp_msb;
  } mexp_sts_t;

endpackage
`default_nettype wire

// ----- design/modular_exponentiation_top.sv -----
// top level of the modular exponentiation block
//
//  channel  dir  tdata fields (low bit up)          handshake
//  in_      in   base, exponent                     in_tvalid / in_tready
//  out_     out  residue                            out_tvalid / out_tready
//  cfg_     in   modulus                            cfg_wr_en
//
// an item reduces the base, then squares for every exponent bit and multiplies for each set bit;
// the serial modular multiply takes one multiplier bit per cycle
// one item in flight, the next accepted while a result waits
// synchronous active-low reset, modulus resets to 101
// a stalled output holds the finished item and delays the start of writing the next result
`default_nettype none
module modular_exponentiation_top #(
  parameter int unsigned WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [WIDTH-1:0]                  cfg_wr_data,  // modulus
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((2*WIDTH+7)/8)*8-1:0]      in_tdata,     // base, exponent
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [((WIDTH+7)/8)*8-1:0]             out_tdata     // residue
);
  import mexp_pkg::*;

  localparam int unsigned OUT_W = ((WIDTH + 7) / 8) * 8;

  mexp_cmd_t        cmd;
  mexp_sts_t        sts;
  logic [WIDTH-1:0] residue;

  mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mexp_dp #(.WIDTH(WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .base        (in_tdata[WIDTH-1:0]),
    .exponent    (in_tdata[2*WIDTH-1:WIDTH]),
    .cmd         (cmd),
    .sts         (sts),
    .residue     (residue)
  );

  assign out_tdata = OUT_W'(residue);

endmodule
`default_nettype wire

// ----- design/mexp_dp.sv -----
// datapath: modulus register, base reduction, serial modular multiply, result register
`default_nettype none
module mexp_dp #(
  parameter int unsigned WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [WIDTH-1:0]  cfg_wr_data,
  input  wire logic [WIDTH-1:0]  base,
  input  wire logic [WIDTH-1:0]  exponent,
  input  wire mexp_pkg::mexp_cmd_t cmd,
  output mexp_pkg::mexp_sts_t    sts,
  output logic [WIDTH-1:0]       residue
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] bs_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] exp_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] pacc_r;
  logic [WIDTH-1:0] mq_r;
  logic [WIDTH-1:0] res_r;

  logic [WIDTH:0]   r2;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH+1:0] s;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH-1:0] pacc_nxt;
  logic             m_small;

  // one bit of the base a step
  always_comb begin
    r2 = {rem_r, bs_r[WIDTH-1]};
    if (r2 >= {1'b0, m_r}) begin
      rem_nxt = WIDTH'(r2 - {1'b0, m_r});
    end else begin
      rem_nxt = r2[WIDTH-1:0];
    end
  end

  // double and add, sum below three times the modulus, then reduced by subtracting the modulus or twice it
  always_comb begin
    m1 = {2'b00, m_r};
    m2 = {1'b0, m_r, 1'b0};
    s  = {1'b0, pacc_r, 1'b0} + (mq_r[WIDTH-1] ? {2'b00, acc_r} : '0);
    if (s >= m2) begin
      pacc_nxt = WIDTH'(s - m2);
    end else if (s >= m1) begin
      pacc_nxt = WIDTH'(s - m1);
    end else begin
      pacc_nxt = s[WIDTH-1:0];
    end
  end

  assign m_small = (m_r[WIDTH-1:1] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= WIDTH'(MOD_RESET);
    end else if (cfg_wr_en) begin
      m_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bs_r   <= base;
      exp_r  <= exponent;
      rem_r  <= '0;
      acc_r  <= WIDTH'(1);
      pacc_r <= WIDTH'(1);
    end else begin
      if (cmd.red_step) begin
        rem_r <= rem_nxt;
        bs_r  <= bs_r << 1;
      end
      if (cmd.exp_shift) begin
        exp_r <= exp_r << 1;
      end
      if (cmd.mul_commit) begin
        acc_r <= pacc_r;
      end
      if (cmd.mul_init) begin
        pacc_r <= '0;
        mq_r   <= cmd.init_sel_b ? rem_r : pacc_r;
      end else if (cmd.mul_step) begin
        pacc_r <= pacc_nxt;
        mq_r   <= mq_r << 1;
      end
    end
    if (cmd.out_load) begin
      res_r <= m_small ? '0 : acc_r;
    end
  end

  assign sts.exp_msb = exp_r[WIDTH-1];
  assign residue     = res_r;

endmodule
`default_nettype wire

// ----- design/mexp_ctrl.sv -----
// controller: sequencing of reduction, square and multiply steps, output handshake
`default_nettype none
module mexp_ctrl #(
  parameter int unsigned WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire mexp_pkg::mexp_sts_t sts,
  output mexp_pkg::mexp_cmd_t   cmd
);
  import mexp_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RED    = 3'd1;
  localparam logic [2:0] S_SQ     = 3'd2;
  localparam logic [2:0] S_COM_SQ = 3'd3;
  localparam logic [2:0] S_MB     = 3'd4;
  localparam logic [2:0] S_COM_MB = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] bit_r, bit_nxt;
  logic          ovld_r, ovld_nxt;
  logic          cnt_last;
  logic          bit_last;
  logic          out_free;

  assign cnt_last  = (cnt_r == CW'(WIDTH - 1));
  assign bit_last  = (bit_r == CW'(WIDTH - 1));
  assign out_free  = !ovld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt      = '0;
          cmd.mul_init = 1'b1;
          state_nxt    = S_SQ;
        end
      end
      S_SQ, S_MB: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == S_SQ) ? S_COM_SQ : S_COM_MB;
        end
      end
      S_COM_SQ, S_COM_MB: begin
        cmd.mul_commit = 1'b1;
        if (state_r == S_COM_SQ && sts.exp_msb) begin
          cmd.mul_init   = 1'b1;
          cmd.init_sel_b = 1'b1;
          state_nxt      = S_MB;
        end else begin
          cmd.exp_shift = 1'b1;
          if (bit_last) begin
            state_nxt = S_FIN;
          end else begin
            bit_nxt      = bit_r + 1'b1;
            cmd.mul_init = 1'b1;
            state_nxt    = S_SQ;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      ovld_nxt = 1'b1;
    end else if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovld_r || out_tready))
    else $error("result register overwritten while occupied");

  a_cnt_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid) |=> (cnt_r == '0 && bit_r == '0))
    else $error("counters not cleared at item start");

  a_fin_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> bit_last)
    else $error("finished before all exponent bits");

  a_mul_align: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_init |=> (cnt_r == '0))
    else $error("multiply started with step counter misaligned");

endmodule
`default_nettype wire
